// ===== rtl/fsme_pkg.sv =====
// Shared types and constants for the flow-shop makespan evaluator.
// Holds field widths, register indexes, action codes and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package fsme_pkg;

  // Field widths fixed by the interface.
  localparam int TIME_W    = 7;
  localparam int SPAN_W    = 12;
  localparam int ORDER_W   = 32;
  localparam int NIB_W     = 4;
  localparam int JOBCFG_W  = 4;
  localparam int MACHCFG_W = 2;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int IDXIN_W   = 3;
  // Width used for job-number compares; holds every job count up to 16.
  localparam int CMP_W     = 5;

  localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

  // Parameter defaults.
  localparam int MAX_JOBS_DEF = 8;
  localparam int MACHINES_DEF = 3;

  // Configuration register reset values.
  localparam logic [JOBCFG_W-1:0]  JOBS_RST = 4'd8;
  localparam logic [MACHCFG_W-1:0] MACH_RST = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_JOBS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MACH = 1'b1;

  // Request actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // Machine selectors for the time triple.
  localparam logic [1:0] MACH_FIRST  = 2'd0;
  localparam logic [1:0] MACH_SECOND = 2'd1;

  // One job's processing times, first machine in the low bits.
  typedef struct packed {
    logic [TIME_W-1:0] third;
    logic [TIME_W-1:0] second;
    logic [TIME_W-1:0] first;
  } job_times_t;

endpackage

// ===== rtl/flow_shop_makespan_evaluator.sv =====
// Flow-shop makespan evaluator. A load request writes the job table and the block
// stays ready. An evaluate request (n jobs, m machines) passes the order check,
// then steps each job and machine in turn through the single shared max-plus unit,
// then waits in S_DONE until the output is free; no new request is taken until it is
// back in idle. A bad order or zero jobs goes straight from the check to S_DONE.
// Synchronous reset clears the sequencer, out_valid and completion times; sets 8 jobs, 3 machines.
`timescale 1ns / 1ps

module flow_shop_makespan_evaluator import fsme_pkg::*; #(
  parameter int MAX_JOBS = MAX_JOBS_DEF,
  parameter int MACHINES = MACHINES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration port.
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // Request channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [IDXIN_W-1:0]   in_job_index,
  input  logic [TIME_W-1:0]    in_time_first,
  input  logic [TIME_W-1:0]    in_time_second,
  input  logic [TIME_W-1:0]    in_time_third,
  input  logic [ORDER_W-1:0]   in_job_order,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SPAN_W-1:0]    out_makespan,
  output logic                 out_bad_order
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int POS_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int MI_W  = (MACHINES > 1) ? $clog2(MACHINES) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_RUN   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [JOBCFG_W-1:0]    jobs_cfg_r;
  logic [MACHCFG_W-1:0]   mach_cfg_r;
  logic [CNT_W-1:0]       n_r;
  logic [MACHCFG_W-1:0]   m_r;
  logic [ORDER_W-1:0]     order_r;
  logic [POS_W-1:0]       p_r;
  logic [MI_W-1:0]        k_r;
  logic [SPAN_W-1:0]      prev_r;
  logic [SPAN_W-1:0]      fin_r [MACHINES];
  logic [SPAN_W-1:0]      res_span_r;
  logic                   res_bad_r;
  logic                   out_valid_r;
  logic [SPAN_W-1:0]      out_makespan_r;
  logic                   out_bad_order_r;

  logic                   in_fire;
  logic                   eval_fire;
  logic                   load_fire;
  logic [CNT_W-1:0]       n_clamped;
  logic [MACHCFG_W-1:0]   m_clamped;
  logic [2*ORDER_W-1:0]   order_ext;
  logic [POS_W-1:0]       rd_pos;
  logic [NIB_W-1:0]       rd_job;
  logic                   order_bad;
  logic                   last_mach;
  logic                   last_job;
  logic                   out_free;
  logic [POS_W-1:0]       wr_addr;
  logic                   wr_ok;
  job_times_t             wr_times;
  job_times_t             rd_times;
  logic [TIME_W-1:0]      step_time;
  logic [SPAN_W-1:0]      step_finish;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign eval_fire = in_fire && (in_action == ACT_EVAL);
  assign load_fire = in_fire && (in_action == ACT_LOAD);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jobs_cfg_r <= JOBS_RST;
      mach_cfg_r <= MACH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_JOBS: jobs_cfg_r <= cfg_wdata[JOBCFG_W-1:0];
        REG_MACH: mach_cfg_r <= cfg_wdata[MACHCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the job and machine counts to what the hardware holds.
  always_comb begin
    if (CMP_W'(jobs_cfg_r) > CMP_W'(MAX_JOBS)) begin
      n_clamped = CNT_W'(MAX_JOBS);
    end else begin
      n_clamped = CNT_W'(jobs_cfg_r);
    end
    if (mach_cfg_r == '0) begin
      m_clamped = MACHCFG_W'(1);
    end else if (mach_cfg_r > MACHCFG_W'(MACHINES)) begin
      m_clamped = MACHCFG_W'(MACHINES);
    end else begin
      m_clamped = mach_cfg_r;
    end
  end

  // Order positions past the 32-bit word read as job 0.
  assign order_ext = {{ORDER_W{1'b0}}, order_r};

  // Fetch job times in the cycle before use: the current job while its machines are
  // stepped, the following job once its last machine is being stepped.
  assign rd_pos = ((state_r == S_RUN) && last_mach) ? p_r + POS_W'(1) : p_r;
  assign rd_job = order_ext[{rd_pos, 2'b00} +: NIB_W];

  // Order check: any position in use naming a job at or above the count.
  always_comb begin
    logic [NIB_W-1:0] nib;
    order_bad = 1'b0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      nib = order_ext[i*NIB_W +: NIB_W];
      if ((CNT_W'(i) < n_r) && (CMP_W'(nib) >= CMP_W'(n_r))) begin
        order_bad = 1'b1;
      end
    end
  end

  // Job time table, written by load requests.
  assign wr_ok    = CMP_W'(in_job_index) < CMP_W'(MAX_JOBS);
  assign wr_addr  = POS_W'(in_job_index);
  assign wr_times = '{third: in_time_third, second: in_time_second, first: in_time_first};

  fsme_times #(
    .DEPTH (MAX_JOBS),
    .AW    (POS_W)
  ) u_times (
    .clk     (clk),
    .wr_en   (load_fire && wr_ok),
    .wr_addr (wr_addr),
    .wr_data (wr_times),
    .rd_addr (rd_job[POS_W-1:0]),
    .rd_data (rd_times)
  );

  // Pick the current machine's time for the shared unit.
  always_comb begin
    unique case (MACHCFG_W'(k_r))
      MACH_FIRST:  step_time = rd_times.first;
      MACH_SECOND: step_time = rd_times.second;
      default:     step_time = rd_times.third;
    endcase
  end

  fsme_mpu u_mpu (
    .mach_done (fin_r[k_r]),
    .job_done  (prev_r),
    .proc_time (step_time),
    .finish    (step_finish)
  );

  assign last_mach = (MACHCFG_W'(k_r) == (m_r - MACHCFG_W'(1)));
  assign last_job  = (CNT_W'(p_r) == (n_r - CNT_W'(1)));
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (eval_fire) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (order_bad || (n_r == '0)) state_nxt = S_DONE;
        else state_nxt = S_RUN;
      end
      S_RUN: begin
        if (last_mach && last_job) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and per-machine completion times.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_r         <= '0;
      k_r         <= '0;
      prev_r      <= '0;
      for (int i = 0; i < MACHINES; i++) begin
        fin_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (eval_fire) begin
        p_r    <= '0;
        k_r    <= '0;
        prev_r <= '0;
        for (int i = 0; i < MACHINES; i++) begin
          fin_r[i] <= '0;
        end
      end else if (state_r == S_RUN) begin
        fin_r[k_r] <= step_finish;
        if (last_mach) begin
          k_r    <= '0;
          prev_r <= '0;
          p_r    <= p_r + POS_W'(1);
        end else begin
          k_r    <= k_r + MI_W'(1);
          prev_r <= step_finish;
        end
      end
    end
  end

  // Request latch and result payload.
  always_ff @(posedge clk) begin
    if (eval_fire) begin
      order_r <= in_job_order;
      n_r     <= n_clamped;
      m_r     <= m_clamped;
    end
    if (state_r == S_CHECK) begin
      res_span_r <= '0;
      res_bad_r  <= order_bad;
    end else if ((state_r == S_RUN) && last_mach && last_job) begin
      res_span_r <= step_finish;
      res_bad_r  <= 1'b0;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_makespan_r  <= res_span_r;
      out_bad_order_r <= res_bad_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_makespan  = out_makespan_r;
  assign out_bad_order = out_bad_order_r;

  // An evaluate request always passes through the order check first.
  assert property (@(posedge clk) disable iff (!rst_n)
    eval_fire |=> (state_r == S_CHECK))
    else $error("evaluate request did not enter the order check");

  // The job position stays inside the order while iterating.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (CNT_W'(p_r) < n_r))
    else $error("job position ran past the job count");

  // The machine counter stays inside the machines in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (MACHCFG_W'(k_r) < m_r))
    else $error("machine counter ran past the machine count");

  // A rejected order reports a zero makespan.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_order_r) |-> (out_makespan_r == '0))
    else $error("bad order carries a nonzero makespan");

endmodule

// ===== rtl/fsme_times.sv =====
// Job time table: one time triple per job, written by load requests.
// Depends on fsme_pkg for the job_times_t entry type.
`timescale 1ns / 1ps

module fsme_times import fsme_pkg::*; #(
  parameter int DEPTH = MAX_JOBS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  job_times_t    wr_data,
  input  logic [AW-1:0] rd_addr,
  output job_times_t    rd_data
);

  // Entries are undefined until a load request writes them.
  job_times_t times_r [DEPTH];
  job_times_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      times_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the address is presented in the cycle before the data is used.
  always_ff @(posedge clk) begin
    rd_data_r <= times_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fsme_mpu.sv =====
// Shared max-plus unit: saturating time + max(two completion times).
// Depends on fsme_pkg for widths and the saturation limit.
`timescale 1ns / 1ps

module fsme_mpu import fsme_pkg::*; (
  input  logic [SPAN_W-1:0] mach_done,
  input  logic [SPAN_W-1:0] job_done,
  input  logic [TIME_W-1:0] proc_time,
  output logic [SPAN_W-1:0] finish
);

  logic [SPAN_W-1:0] start;
  logic [SPAN_W:0]   sum;

  // Start when both the machine and the job are free, then add the time.
  always_comb begin
    start  = (mach_done > job_done) ? mach_done : job_done;
    sum    = {1'b0, start} + {{(SPAN_W + 1 - TIME_W){1'b0}}, proc_time};
    finish = sum[SPAN_W] ? SPAN_MAX : sum[SPAN_W-1:0];
  end

endmodule

// ===== verif/fsme_checker.sv =====
// Scoreboard for the flow-shop makespan evaluator: watches the register port and both channels.
// It predicts each evaluation's makespan from its own copy of the job table and compares results.
// Depends on fsme_pkg for field widths, register indexes and action codes.
`timescale 1ns / 1ps

module fsme_checker import fsme_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_action,
  input  logic [IDXIN_W-1:0]   in_job_index,
  input  logic [TIME_W-1:0]    in_time_first,
  input  logic [TIME_W-1:0]    in_time_second,
  input  logic [TIME_W-1:0]    in_time_third,
  input  logic [ORDER_W-1:0]   in_job_order,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [SPAN_W-1:0]    out_makespan,
  input  logic                 out_bad_order,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   bad_seen
);

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic              bad;
  } span_result_t;

  // Shadow copies of the job table and the two count registers.
  job_times_t              times_table [MAX_JOBS_DEF];
  logic [JOBCFG_W-1:0]     jobs_reg;
  logic [MACHCFG_W-1:0]    mach_reg;
  span_result_t            span_queue [$];

  // Runs the max-plus recurrence over one job order with the current counts.
  function automatic span_result_t compute_makespan(input logic [ORDER_W-1:0] order);
    int           n;
    int           m;
    int           job;
    int           prev;
    int           start;
    int           sum;
    int           t;
    int           finish [MACHINES_DEF];
    span_result_t r;
    n = (jobs_reg > MAX_JOBS_DEF) ? MAX_JOBS_DEF : int'(jobs_reg);
    m = (mach_reg == 0) ? 1 : int'(mach_reg);
    if (m > MACHINES_DEF) m = MACHINES_DEF;
    r = '0;
    // Any entry naming a job outside the count flags the whole order.
    for (int p = 0; p < n; p++) begin
      if (int'(order[NIB_W*p +: NIB_W]) >= n) r.bad = 1'b1;
    end
    if (r.bad) return r;
    for (int k = 0; k < MACHINES_DEF; k++) finish[k] = 0;
    for (int p = 0; p < n; p++) begin
      job  = int'(order[NIB_W*p +: NIB_W]);
      prev = 0;
      for (int k = 0; k < m; k++) begin
        case (k)
          0:       t = int'(times_table[job].first);
          1:       t = int'(times_table[job].second);
          default: t = int'(times_table[job].third);
        endcase
        start     = (finish[k] > prev) ? finish[k] : prev;
        sum       = start + t;
        finish[k] = (sum > int'(SPAN_MAX)) ? int'(SPAN_MAX) : sum;
        prev      = finish[k];
      end
    end
    if (n > 0) r.span = finish[m-1][SPAN_W-1:0];
    return r;
  endfunction

  // Prints the first few failures in full, later ones are only counted.
  task automatic note_failure(input string what, input span_result_t want,
                              input span_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected makespan %0d bad %0b, got makespan %0d bad %0b",
               $realtime, what, want.span, want.bad, got.span, got.bad);
    end
  endtask

  // Results are checked before new requests are queued, so a request accepted
  // on the same edge can never be matched against an older result. A register
  // write on the same edge as a request only affects later requests.
  always @(posedge clk) begin
    span_result_t got;
    span_result_t want;
    if (!rst_n) begin
      jobs_reg = JOBS_RST;
      mach_reg = MACH_RST;
      for (int j = 0; j < MAX_JOBS_DEF; j++) times_table[j] = '0;
      span_queue.delete();
      fail_count   = 0;
      results_seen = 0;
      bad_seen     = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.span = out_makespan;
        got.bad  = out_bad_order;
        results_seen++;
        if (got.bad) bad_seen++;
        if (span_queue.size() == 0) begin
          note_failure("result with no request pending", '0, got);
        end else begin
          want = span_queue.pop_front();
          if (got.span !== want.span || got.bad !== want.bad) begin
            note_failure("result mismatch", want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_LOAD) begin
          times_table[in_job_index] = '{third: in_time_third, second: in_time_second,
                                        first: in_time_first};
        end else begin
          span_queue.push_back(compute_makespan(in_job_order));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_JOBS: jobs_reg = cfg_wdata[JOBCFG_W-1:0];
          REG_MACH: mach_reg = cfg_wdata[MACHCFG_W-1:0];
          default: ;
        endcase
      end
    end
    pending = span_queue.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the flow-shop makespan evaluator testbench: clock, reset, register writes and requests.
// Instantiates flow_shop_makespan_evaluator and fsme_checker, which does all prediction.
// Depends on fsme_pkg for widths, register indexes and action codes.
`timescale 1ns / 1ps

module tb_top;
  import fsme_pkg::*;

  localparam int PHASES          = 11;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 400000;

  // Register settings and idle mix of each random phase.
  localparam int PH_JOBS [PHASES] = '{8, 1, 0, 15, 4, 12, 3, 8, 6, 2, 5};
  localparam int PH_MACH [PHASES] = '{3, 1, 2, 0, 2, 3, 3, 1, 2, 3, 1};
  localparam int PH_SEND [PHASES] = '{0, 66, 0, 28, 0, 66, 0, 28, 28, 0, 66};
  localparam int PH_RECV [PHASES] = '{0, 0, 66, 28, 0, 0, 66, 28, 28, 0, 0};
  localparam bit PH_HOLD [PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_action;
  logic [IDXIN_W-1:0]   in_job_index;
  logic [TIME_W-1:0]    in_time_first;
  logic [TIME_W-1:0]    in_time_second;
  logic [TIME_W-1:0]    in_time_third;
  logic [ORDER_W-1:0]   in_job_order;
  logic                 out_valid;
  logic                 out_ready;
  logic [SPAN_W-1:0]    out_makespan;
  logic                 out_bad_order;

  int fail_count;
  int pending;
  int results_seen;
  int bad_seen;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holds_asked    = 0;
  int holds_served   = 0;
  int jobs_setting   = 8;
  int loads_sent     = 0;
  int evals_sent     = 0;
  int cycle_count    = 0;

  always #5 clk = ~clk;

  flow_shop_makespan_evaluator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_job_index   (in_job_index),
    .in_time_first  (in_time_first),
    .in_time_second (in_time_second),
    .in_time_third  (in_time_third),
    .in_job_order   (in_job_order),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_makespan   (out_makespan),
    .out_bad_order  (out_bad_order)
  );

  fsme_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_job_index   (in_job_index),
    .in_time_first  (in_time_first),
    .in_time_second (in_time_second),
    .in_time_third  (in_time_third),
    .in_job_order   (in_job_order),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_makespan   (out_makespan),
    .out_bad_order  (out_bad_order),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .bad_seen       (bad_seen)
  );

  // Result side: random stalls, or a long hold-off when one is asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Cycle limit for the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // One register write; each write starts on its own falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one request, with random idle cycles first, and returns on the
  // falling edge after it was accepted.
  task automatic offer_request(input logic act, input logic [IDXIN_W-1:0] idx,
                               input logic [TIME_W-1:0] t_first,
                               input logic [TIME_W-1:0] t_second,
                               input logic [TIME_W-1:0] t_third,
                               input logic [ORDER_W-1:0] order);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_job_index   <= idx;
    in_time_first  <= t_first;
    in_time_second <= t_second;
    in_time_third  <= t_third;
    in_job_order   <= order;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (act == ACT_LOAD) loads_sent++;
    else evals_sent++;
  endtask

  // Mostly loads and well-formed orders; the rest are orders with an entry
  // outside the job count.
  task automatic send_random_request();
    int                 roll;
    int                 n;
    int                 pick;
    int                 tmp;
    int                 perm [MAX_JOBS_DEF];
    logic [ORDER_W-1:0] order;
    logic [IDXIN_W-1:0] idx;
    logic [TIME_W-1:0]  t_first;
    logic [TIME_W-1:0]  t_second;
    logic [TIME_W-1:0]  t_third;
    roll     = $urandom_range(99);
    n        = (jobs_setting > MAX_JOBS_DEF) ? MAX_JOBS_DEF : jobs_setting;
    order    = $urandom();
    idx      = IDXIN_W'($urandom_range(MAX_JOBS_DEF - 1));
    t_first  = TIME_W'($urandom_range(127));
    t_second = TIME_W'($urandom_range(127));
    t_third  = TIME_W'($urandom_range(127));
    if (roll < 25) begin
      offer_request(ACT_LOAD, idx, t_first, t_second, t_third, order);
    end else begin
      if (roll < 55) begin
        // Shuffled permutation of the jobs in use.
        for (int i = 0; i < MAX_JOBS_DEF; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          pick       = $urandom_range(i);
          tmp        = perm[i];
          perm[i]    = perm[pick];
          perm[pick] = tmp;
        end
        for (int p = 0; p < n; p++) order[NIB_W*p +: NIB_W] = NIB_W'(perm[p]);
      end else if (roll < 85) begin
        // Jobs in range, repeats allowed.
        for (int p = 0; p < n; p++) begin
          order[NIB_W*p +: NIB_W] = NIB_W'($urandom_range(n - 1));
        end
      end else if (n > 0) begin
        order[NIB_W*$urandom_range(n - 1) +: NIB_W] = NIB_W'($urandom_range(15, n));
      end
      offer_request(ACT_EVAL, idx, t_first, t_second, t_third, order);
    end
  endtask

  // Waits for every expected result, then for the longest evaluation time.
  task automatic wait_for_drain();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Main sequence: reset, directed requests, then the random phases.
  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_JOBS;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_action      = ACT_LOAD;
    in_job_index   = '0;
    in_time_first  = '0;
    in_time_second = '0;
    in_time_third  = '0;
    in_job_order   = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill the whole table first, so no evaluation ever reads an empty entry.
    offer_request(ACT_LOAD, 3'd0, 7'd0, 7'd0, 7'd0, 32'h0);
    offer_request(ACT_LOAD, 3'd1, 7'd5, 7'd17, 7'd2, 32'hFFFF_FFFF);
    offer_request(ACT_LOAD, 3'd2, 7'd64, 7'd1, 7'd33, 32'h0);
    offer_request(ACT_LOAD, 3'd3, 7'd9, 7'd99, 7'd12, 32'h0);
    offer_request(ACT_LOAD, 3'd4, 7'd42, 7'd42, 7'd0, 32'h0);
    offer_request(ACT_LOAD, 3'd5, 7'd1, 7'd85, 7'd120, 32'h0);
    offer_request(ACT_LOAD, 3'd6, 7'd77, 7'd3, 7'd56, 32'h0);
    offer_request(ACT_LOAD, 3'd7, 7'd127, 7'd127, 7'd127, 32'h0);

    // Directed orders at the reset counts: identity, reverse, all-min, all-max,
    // all-bad, bad entries at the last and first positions, and an alternating one.
    offer_request(ACT_EVAL, 3'd0, 7'd0, 7'd0, 7'd0, 32'h7654_3210);
    offer_request(ACT_EVAL, 3'd7, 7'd127, 7'd127, 7'd127, 32'h0123_4567);
    offer_request(ACT_EVAL, 3'd0, 7'd0, 7'd0, 7'd0, 32'h0000_0000);
    offer_request(ACT_EVAL, 3'd0, 7'd0, 7'd0, 7'd0, 32'h7777_7777);
    offer_request(ACT_EVAL, 3'd0, 7'd0, 7'd0, 7'd0, 32'hFFFF_FFFF);
    offer_request(ACT_EVAL, 3'd0, 7'd0, 7'd0, 7'd0, 32'h8654_3210);
    offer_request(ACT_EVAL, 3'd0, 7'd0, 7'd0, 7'd0, 32'h7654_321F);
    offer_request(ACT_EVAL, 3'd0, 7'd0, 7'd0, 7'd0, 32'h0707_0707);
    in_valid <= 1'b0;
    wait_for_drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_JOBS, CFG_W'(PH_JOBS[ph]));
      write_reg(REG_MACH, CFG_W'(PH_MACH[ph]));
      jobs_setting   = PH_JOBS[ph];
      send_idle_pct  = PH_SEND[ph];
      recv_stall_pct = PH_RECV[ph];
      if (PH_HOLD[ph]) holds_asked++;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_request();
      in_valid <= 1'b0;
      wait_for_drain();
    end

    $display("Covered %0d loads and %0d evaluations over %0d count settings, %0d checked.",
             loads_sent, evals_sent, PHASES + 1, results_seen);
    $display("Of those %0d were bad orders; idle mixes and %0d long output hold-offs were applied.",
             bad_seen, holds_asked);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
